// File: design/touch_and_button_event_generator_unit_macros.svh
// Assertion macros shared by the touch and button event generator RTL.
// Clocked on clk_i and disabled while rst_ni is low.
`ifndef TOUCH_AND_BUTTON_EVENT_GENERATOR_UNIT_MACROS_SVH
`define TOUCH_AND_BUTTON_EVENT_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define TBEG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tbeg assertion failed");

// Next-cycle implication.
`define TBEG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tbeg assertion failed");

`endif

// File: design/tbeg_pkg.sv
// Package for the touch and button event generator: constants, codes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbeg_pkg;

  localparam int SCREEN_WIDTH  = 240;
  localparam int SCREEN_HEIGHT = 320;
  localparam int SCREEN_MAX    = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;

  localparam int RAW_W    = 12;
  localparam int COORD_W  = 9;
  localparam int PINS_W   = 6;
  localparam int KIND_W   = 4;
  localparam int ORIENT_W = 2;
  localparam int SIZE_W   = $clog2(SCREEN_MAX + 1);
  localparam int SCALE_W  = $clog2(SCREEN_MAX);
  localparam int ROT_W    = SCALE_W + 1;
  localparam int NUM_W    = $clog2(((1 << RAW_W) - 1) * SCREEN_MAX + 1);
  localparam int CNT_W    = $clog2(NUM_W + 1);

  localparam int N_SLOTS   = 2 * PINS_W + 1;
  localparam int TOUCH_SLOT = N_SLOTS - 1;
  localparam int SLOT_W    = $clog2(N_SLOTS + 1);

  localparam int N_REGS  = 5;
  localparam int PADDR_W = $clog2(4 * N_REGS);
  localparam int DATA_W  = 32;

  localparam logic [RAW_W-1:0] X_MIN_RST = RAW_W'(220);
  localparam logic [RAW_W-1:0] X_MAX_RST = RAW_W'(3900);
  localparam logic [RAW_W-1:0] Y_MIN_RST = RAW_W'(160);
  localparam logic [RAW_W-1:0] Y_MAX_RST = RAW_W'(3900);

  localparam logic [KIND_W-1:0] KIND_TOUCH_DOWN = 4'd12;
  localparam logic [KIND_W-1:0] KIND_MOVE       = 4'd13;
  localparam logic [KIND_W-1:0] KIND_TOUCH_UP   = 4'd14;

  localparam logic DIR_DOWN = 1'b0;
  localparam logic DIR_UP   = 1'b1;

  typedef enum logic [2:0] {
    REG_X_MIN  = 3'd0,
    REG_X_MAX  = 3'd1,
    REG_Y_MIN  = 3'd2,
    REG_Y_MAX  = 3'd3,
    REG_ORIENT = 3'd4
  } tbeg_reg_e;

  typedef enum logic [ORIENT_W-1:0] {
    ORIENT_VERT        = 2'd0,
    ORIENT_HORIZ       = 2'd1,
    ORIENT_VERT_MIRROR = 2'd2,
    ORIENT_HORIZ_MIRROR = 2'd3
  } tbeg_orient_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_TOUCH,
    ST_EMIT
  } tbeg_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } tbeg_div_stat_t;

endpackage

`default_nettype wire

// File: design/touch_and_button_event_generator_unit.sv
// Touch and button event generator, top level.
// Depends on tbeg_pkg, tbeg_div and the assertion macro header.
//
// Usage: one input beat is one poll (six active-low pins, pen bit, FIFO flag,
// three raw sample bytes). The block turns a poll into zero to thirteen result
// beats: up to six button level events, up to six press-edge events, then at
// most one touch event; last_event marks the final beat of a poll.
// Calibration and orientation must be written by the user over the APB port
// only while idle; the block itself does not enforce it. A poll with a fresh
// sample runs two scalings on one shared multiply-then-divide unit; a poll
// without a sample skips them. After the touch step the sequencer walks the
// thirteen event slots in order, one per cycle while the output is not stalled,
// until none is pending. in_stall_o stays high while a poll is in progress.
// Reset clears all button, touch and sample state and loads the calibration
// defaults. A stalled receiver holds the output register and stops the slot
// walk at the next pending slot until the beat is taken.
`timescale 1ns / 1ps
`default_nettype none

`include "touch_and_button_event_generator_unit_macros.svh"

module touch_and_button_event_generator_unit
  import tbeg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  // poll input
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [PINS_W-1:0]    button_pins_i,
  input  wire logic                 pen_detected_i,
  input  wire logic                 fifo_nonempty_i,
  input  wire logic [7:0]           sample_byte0_i,
  input  wire logic [7:0]           sample_byte1_i,
  input  wire logic [7:0]           sample_byte2_i,
  // event output
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [KIND_W-1:0]         event_kind_o,
  output logic                      direction_o,
  output logic [COORD_W-1:0]        coord_x_o,
  output logic [COORD_W-1:0]        coord_y_o,
  output logic                      last_event_o
);

  // config registers
  logic [RAW_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
  tbeg_orient_e     orient_q;
  logic             cfg_wr;

  // sequencer
  tbeg_state_e      state_q, state_d;
  logic             axis_q, axis_d;
  logic             zero_q, zero_d;
  logic [SCALE_W-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [N_SLOTS-1:0] mask_q, mask_d, dir_q, dir_d;
  logic [KIND_W-1:0]  tkind_q, tkind_d;
  logic [COORD_W-1:0] tx_q, tx_d, ty_q, ty_d;

  // latched poll
  logic             pen_q, pen_d, fifo_q, fifo_d;
  logic [7:0]       b0_q, b0_d, b1_q, b1_d, b2_q, b2_d;

  // persistent state
  logic [PINS_W-1:0]  level_q, level_d, edge_q, edge_d, prev_q, prev_d;
  logic               hv_q, hv_d, was_q, was_d;
  logic [COORD_W-1:0] hx_q, hx_d, hy_q, hy_d, rx_q, rx_d, ry_q, ry_d;

  // output register
  logic               ov_q, ov_d, od_q, od_d, ol_q, ol_d;
  logic [KIND_W-1:0]  ok_q, ok_d;
  logic [COORD_W-1:0] ox_q, ox_d, oy_q, oy_d;

  // datapath
  logic [PINS_W-1:0]  pressed, fresh;
  logic [RAW_W-1:0]   raw_x, raw_y, raw_v, lo_v, hi_v;
  logic [RAW_W:0]     diff, span;
  logic [SIZE_W-1:0]  size_v;
  logic [NUM_W-1:0]   product, size_n, quot;
  logic [SCALE_W-1:0] scaled;
  logic [ROT_W-1:0]   sx_e, sy_e, w_m1, h_m1;
  logic [COORD_W-1:0] px, py, nx, ny;
  logic               hv_n;
  logic               div_start;
  tbeg_div_stat_t     div_stat;
  logic               ld_ok, cur_bit;
  logic [N_SLOTS-1:0] slot_bit, mask_rest;

  // ---------------- configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[PADDR_W-1:2])
      REG_X_MIN:  prdata = DATA_W'(x_min_q);
      REG_X_MAX:  prdata = DATA_W'(x_max_q);
      REG_Y_MIN:  prdata = DATA_W'(y_min_q);
      REG_Y_MAX:  prdata = DATA_W'(y_max_q);
      REG_ORIENT: prdata = DATA_W'(orient_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q  <= X_MIN_RST;
      x_max_q  <= X_MAX_RST;
      y_min_q  <= Y_MIN_RST;
      y_max_q  <= Y_MAX_RST;
      orient_q <= ORIENT_VERT;
    end else if (cfg_wr) begin
      unique case (paddr[PADDR_W-1:2])
        REG_X_MIN:  x_min_q  <= pwdata[RAW_W-1:0];
        REG_X_MAX:  x_max_q  <= pwdata[RAW_W-1:0];
        REG_Y_MIN:  y_min_q  <= pwdata[RAW_W-1:0];
        REG_Y_MAX:  y_max_q  <= pwdata[RAW_W-1:0];
        REG_ORIENT: orient_q <= tbeg_orient_e'(pwdata[ORIENT_W-1:0]);
        default: ;
      endcase
    end
  end

  // ---------------- datapath
  assign pressed = ~button_pins_i;
  assign fresh   = pressed & (button_pins_i ^ prev_q);

  assign raw_x = {b0_q, b1_q[7:4]};
  assign raw_y = ~{b1_q[3:0], b2_q};   // 4095 - y
  assign raw_v = axis_q ? raw_y : raw_x;
  assign lo_v  = axis_q ? y_min_q : x_min_q;
  assign hi_v  = axis_q ? y_max_q : x_max_q;
  assign diff  = {1'b0, raw_v} - {1'b0, lo_v};
  assign span  = {1'b0, hi_v} - {1'b0, lo_v};
  assign size_v  = axis_q ? SIZE_W'(SCREEN_HEIGHT) : SIZE_W'(SCREEN_WIDTH);
  assign size_n  = NUM_W'(size_v);
  assign product = NUM_W'(diff[RAW_W-1:0]) * size_n;

  tbeg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (span[RAW_W-1:0]),
    .stat_o     (div_stat),
    .quotient_o (quot)
  );

  always_comb begin
    if (zero_q) begin
      scaled = '0;
    end else if (quot >= size_n) begin
      scaled = SCALE_W'(size_n - NUM_W'(1));
    end else begin
      scaled = SCALE_W'(quot);
    end
  end

  assign sx_e = ROT_W'(sx_q);
  assign sy_e = ROT_W'(sy_q);
  assign w_m1 = ROT_W'(SCREEN_WIDTH - 1);
  assign h_m1 = ROT_W'(SCREEN_HEIGHT - 1);

  always_comb begin
    unique case (orient_q)
      ORIENT_HORIZ: begin
        px = COORD_W'(h_m1 - sy_e);
        py = COORD_W'(sx_e);
      end
      ORIENT_VERT_MIRROR: begin
        px = COORD_W'(w_m1 - sx_e);
        py = COORD_W'(h_m1 - sy_e);
      end
      ORIENT_HORIZ_MIRROR: begin
        px = COORD_W'(sy_e);
        py = COORD_W'(w_m1 - sx_e);
      end
      default: begin
        px = COORD_W'(sx_e);
        py = COORD_W'(sy_e);
      end
    endcase
  end

  assign hv_n = pen_q && (fifo_q || hv_q);
  assign nx   = (pen_q && fifo_q) ? px : hx_q;
  assign ny   = (pen_q && fifo_q) ? py : hy_q;

  assign ld_ok     = !ov_q || !out_stall_i;
  assign cur_bit   = (slot_q <= SLOT_W'(TOUCH_SLOT)) && mask_q[slot_q];
  assign slot_bit  = N_SLOTS'(1) << slot_q;
  assign mask_rest = mask_q & ~slot_bit;

  // ---------------- sequencer
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    zero_d  = zero_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    slot_d  = slot_q;
    mask_d  = mask_q;
    dir_d   = dir_q;
    tkind_d = tkind_q;
    tx_d    = tx_q;
    ty_d    = ty_q;
    pen_d   = pen_q;
    fifo_d  = fifo_q;
    b0_d    = b0_q;
    b1_d    = b1_q;
    b2_d    = b2_q;
    level_d = level_q;
    edge_d  = edge_q;
    prev_d  = prev_q;
    hv_d    = hv_q;
    was_d   = was_q;
    hx_d    = hx_q;
    hy_d    = hy_q;
    rx_d    = rx_q;
    ry_d    = ry_q;
    ov_d    = ov_q && out_stall_i;
    ok_d    = ok_q;
    od_d    = od_q;
    ol_d    = ol_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    div_start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pen_d   = pen_detected_i;
          fifo_d  = fifo_nonempty_i;
          b0_d    = sample_byte0_i;
          b1_d    = sample_byte1_i;
          b2_d    = sample_byte2_i;
          mask_d  = {1'b0, fresh ^ edge_q, pressed ^ level_q};
          dir_d   = {1'b0, ~fresh, ~pressed};
          level_d = pressed;
          edge_d  = fresh;
          prev_d  = button_pins_i;
          axis_d  = 1'b0;
          state_d = (pen_detected_i && fifo_nonempty_i) ? ST_MUL : ST_TOUCH;
        end
      end
      ST_MUL: begin
        div_start = 1'b1;
        zero_d    = diff[RAW_W] || (diff == '0) || span[RAW_W] || (span == '0);
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (!axis_q) begin
            sx_d    = scaled;
            axis_d  = 1'b1;
            state_d = ST_MUL;
          end else begin
            sy_d    = scaled;
            state_d = ST_TOUCH;
          end
        end
      end
      ST_TOUCH: begin
        hv_d = hv_n;
        if (hv_n) begin
          hx_d = nx;
          hy_d = ny;
          if (!was_q || nx != rx_q || ny != ry_q) begin
            mask_d[TOUCH_SLOT] = 1'b1;
            dir_d[TOUCH_SLOT]  = DIR_DOWN;
            tkind_d = was_q ? KIND_MOVE : KIND_TOUCH_DOWN;
            tx_d    = nx;
            ty_d    = ny;
            rx_d    = nx;
            ry_d    = ny;
          end
          was_d = 1'b1;
        end else begin
          if (was_q) begin
            mask_d[TOUCH_SLOT] = 1'b1;
            dir_d[TOUCH_SLOT]  = DIR_UP;
            tkind_d = KIND_TOUCH_UP;
            tx_d    = rx_q;
            ty_d    = ry_q;
          end
          was_d = 1'b0;
        end
        slot_d  = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (mask_q == '0) begin
          state_d = ST_IDLE;
        end else if (!cur_bit) begin
          slot_d = slot_q + SLOT_W'(1);
        end else if (ld_ok) begin
          ov_d = 1'b1;
          od_d = dir_q[slot_q];
          ol_d = (mask_rest == '0);
          if (slot_q == SLOT_W'(TOUCH_SLOT)) begin
            ok_d = tkind_q;
            ox_d = tx_q;
            oy_d = ty_q;
          end else begin
            ok_d = KIND_W'(slot_q);
            ox_d = '0;
            oy_d = '0;
          end
          mask_d = mask_rest;
          slot_d = slot_q + SLOT_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= 1'b0;
      zero_q  <= 1'b0;
      sx_q    <= '0;
      sy_q    <= '0;
      slot_q  <= '0;
      mask_q  <= '0;
      dir_q   <= '0;
      tkind_q <= '0;
      tx_q    <= '0;
      ty_q    <= '0;
      pen_q   <= 1'b0;
      fifo_q  <= 1'b0;
      b0_q    <= '0;
      b1_q    <= '0;
      b2_q    <= '0;
      level_q <= '0;
      edge_q  <= '0;
      prev_q  <= '0;
      hv_q    <= 1'b0;
      was_q   <= 1'b0;
      hx_q    <= '0;
      hy_q    <= '0;
      rx_q    <= '0;
      ry_q    <= '0;
      ov_q    <= 1'b0;
      ok_q    <= '0;
      od_q    <= 1'b0;
      ol_q    <= 1'b0;
      ox_q    <= '0;
      oy_q    <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      zero_q  <= zero_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      slot_q  <= slot_d;
      mask_q  <= mask_d;
      dir_q   <= dir_d;
      tkind_q <= tkind_d;
      tx_q    <= tx_d;
      ty_q    <= ty_d;
      pen_q   <= pen_d;
      fifo_q  <= fifo_d;
      b0_q    <= b0_d;
      b1_q    <= b1_d;
      b2_q    <= b2_d;
      level_q <= level_d;
      edge_q  <= edge_d;
      prev_q  <= prev_d;
      hv_q    <= hv_d;
      was_q   <= was_d;
      hx_q    <= hx_d;
      hy_q    <= hy_d;
      rx_q    <= rx_d;
      ry_q    <= ry_d;
      ov_q    <= ov_d;
      ok_q    <= ok_d;
      od_q    <= od_d;
      ol_q    <= ol_d;
      ox_q    <= ox_d;
      oy_q    <= oy_d;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = ov_q;
  assign event_kind_o = ok_q;
  assign direction_o  = od_q;
  assign coord_x_o    = ox_q;
  assign coord_y_o    = oy_q;
  assign last_event_o = ol_q;

  // ---------------- assertions
  `TBEG_ASSERT_IMP(a_idle_mask_empty, state_q == ST_IDLE, mask_q == '0)
  `TBEG_ASSERT_IMP(a_div_idle_outside, (state_q == ST_IDLE) || (state_q == ST_EMIT),
                   !div_stat.busy)
  `TBEG_ASSERT_IMP(a_div_start_src, div_start, state_q == ST_MUL)
  `TBEG_ASSERT_NXT(a_touch_to_emit, state_q == ST_TOUCH, state_q == ST_EMIT)

endmodule

`default_nettype wire

// File: design/tbeg_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tbeg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbeg_div
  import tbeg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [NUM_W-1:0]     dividend_i,
  input  wire logic [RAW_W-1:0]     divisor_i,
  output tbeg_div_stat_t            stat_o,
  output logic [NUM_W-1:0]          quotient_o
);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [RAW_W:0]   rem_q, rem_d;
  logic [RAW_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [RAW_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q[RAW_W-1:0], quo_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

`default_nettype wire
